/* sv/pwmrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PWM request to register write package
// Shared types and constants for the duty-to-register-write converter.
// ----------------------------------------------------------------------------
package pwmrw_pkg;

    localparam int DEV_W     = 3;
    localparam int CHAN_W    = 5;
    localparam int PCT_W     = 7;
    localparam int ADDR7_W   = 7;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;
    localparam int COUNT_W   = 16;
    localparam int MAX_DEVICES = 7;

    typedef logic [DEV_W-1:0]     dev_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [PCT_W-1:0]     pct_t;
    typedef logic [ADDR7_W-1:0]   addr7_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
    typedef logic [COUNT_W-1:0]   count_t;

    localparam cfg_idx_t CFG_DELAY          = 3'd0;
    localparam cfg_idx_t CFG_BUS_ADDR_FIRST = 3'd1;

    localparam pct_t   PCT_MAX        = 7'd100;
    localparam pct_t   DELAY_RST      = 7'd10;
    localparam chan_t  CHANNEL_COUNT  = 5'd16;
    localparam byte_t  FIRST_LED_REG  = 8'h06;
    localparam byte_t  FULL_ON_BIT    = 8'h10;
    localparam byte_t  NIBBLE_MASK    = 8'h0f;
    localparam int     ROUND_HALF     = 50;

    // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2**30.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd42949673;

    localparam addr7_t BUS_ADDR_RST [MAX_DEVICES] =
        '{7'd64, 7'd65, 7'd66, 7'd68, 7'd72, 7'd80, 7'd96};

endpackage : pwmrw_pkg
`default_nettype wire

/* sv/pwmrw_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PWM request channel
// Valid/ready channel that carries one duty request per transfer.
// ----------------------------------------------------------------------------
interface pwmrw_req_if
    import pwmrw_pkg::*;
();
    logic  valid;
    logic  ready;
    dev_t  device_number;
    chan_t channel;
    pct_t  pwm_percent;

    modport source
    (
        output valid,
        output device_number,
        output channel,
        output pwm_percent,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  device_number,
        input  channel,
        input  pwm_percent,
        output ready
    );
endinterface : pwmrw_req_if
`default_nettype wire

/* sv/pwmrw_wr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel that carries one bus register write per transfer.
// ----------------------------------------------------------------------------
interface pwmrw_wr_if
    import pwmrw_pkg::*;
();
    logic   valid;
    logic   ready;
    addr7_t slave_address;
    byte_t  register_address;
    byte_t  register_data;
    logic   last;

    modport source
    (
        output valid,
        output slave_address,
        output register_address,
        output register_data,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  slave_address,
        input  register_address,
        input  register_data,
        input  last,
        output ready
    );
endinterface : pwmrw_wr_if
`default_nettype wire

/* sv/pwm_percent_to_register_writes_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PWM percent to register writes unit
// Turns a duty request into the four on/off count writes of one channel.
// ----------------------------------------------------------------------------
// Usage: a request on req names a device, a channel and a duty percent. Each
// accepted request with a device in 1..DEVICE_COUNT and a channel in 1..16
// produces four transfers on wr, to the ON_L, ON_H, OFF_L and OFF_H registers
// of that channel, with last set on the fourth. Other requests are accepted
// and produce nothing. Configuration is written through cfg_we, cfg_index and
// cfg_data while the block is idle: index 0 is the delay percent, indexes
// 1 and up hold the device bus addresses.
// The first write is valid once the request has passed the scale, reciprocal
// multiply and count stages. The output stage holds one request and sends
// one write per cycle while wr.ready is high, so it takes a new request only
// after the fourth write is taken; the three earlier stages take new requests
// every cycle while they have room.
// Reset restores the default delay and bus addresses and empties every stage.
// When the receiver holds ready low, the current write stays on wr, the
// stages behind it fill, and req.ready falls once all of them are full.
// ----------------------------------------------------------------------------
module pwm_percent_to_register_writes_unit
    import pwmrw_pkg::*;
#(
    parameter int PWM_STEPS    = 4096,
    parameter int DEVICE_COUNT = 7
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pwmrw_req_if.sink     req,
    pwmrw_wr_if.source    wr,
    input  wire logic     cfg_we,
    input  wire cfg_idx_t cfg_index,
    input  wire cfg_dat_t cfg_data
);

    localparam int NUM_W  = $clog2(100 * PWM_STEPS + ROUND_HALF + 1);
    localparam int STEP_W = $clog2(PWM_STEPS + 1);
    localparam int PROD_W = NUM_W + RECIP_W;
    localparam logic [NUM_W-1:0] STEPS_N = NUM_W'(PWM_STEPS);
    localparam logic [NUM_W-1:0] HALF_N  = NUM_W'(ROUND_HALF);
    localparam count_t STEPS_C = COUNT_W'(PWM_STEPS);

    // Configuration registers.
    pct_t   delay_reg;
    addr7_t bus_addr_reg [DEVICE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RST;
            for (int i = 0; i < DEVICE_COUNT; i++)
            begin
                bus_addr_reg[i] <= BUS_ADDR_RST[i];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DELAY)
            begin
                delay_reg <= cfg_data;
            end
            for (int i = 0; i < DEVICE_COUNT; i++)
            begin
                if (cfg_index == CFG_BUS_ADDR_FIRST + CFG_IDX_W'(i))
                begin
                    bus_addr_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Handshake between stages.
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic   s1_ready, s2_ready, s3_ready, s4_free;
    logic [1:0] s4_cnt_reg;
    logic   wr_done;

    assign wr_done  = s4_valid_reg && wr.ready;
    assign s4_free  = !s4_valid_reg || (wr_done && (s4_cnt_reg == 2'd3));
    assign s3_ready = !s3_valid_reg || s4_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // Stage 1: range check, address lookup and scaling by the step count.
    logic   in_range;
    addr7_t s1_addr_next;
    pct_t   pct_sat, delay_sat;
    logic [NUM_W-1:0] s1_d_num_next, s1_t_num_next;
    byte_t  s1_base_next;
    logic [3:0] chan_low;

    always_comb
    begin
        s1_addr_next = '0;
        for (int i = 0; i < DEVICE_COUNT; i++)
        begin
            if (req.device_number == DEV_W'(i + 1))
            begin
                s1_addr_next = bus_addr_reg[i];
            end
        end
        in_range = (req.device_number != '0)
                   && (req.device_number <= DEV_W'(DEVICE_COUNT))
                   && (req.channel != '0)
                   && (req.channel <= CHANNEL_COUNT);
        pct_sat   = (req.pwm_percent > PCT_MAX) ? PCT_MAX : req.pwm_percent;
        delay_sat = (delay_reg > PCT_MAX) ? PCT_MAX : delay_reg;
        s1_d_num_next = NUM_W'(delay_sat) * STEPS_N + HALF_N;
        s1_t_num_next = NUM_W'(pct_sat) * STEPS_N + HALF_N;
        chan_low = 4'(req.channel - CHAN_W'(1));
        s1_base_next = {2'b00, chan_low, 2'b00} + FIRST_LED_REG;
    end

    logic   s1_full_on_reg;
    addr7_t s1_addr_reg;
    byte_t  s1_base_reg;
    logic [NUM_W-1:0] s1_d_num_reg, s1_t_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req.valid && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_full_on_reg <= (req.pwm_percent >= PCT_MAX);
            s1_addr_reg    <= s1_addr_next;
            s1_base_reg    <= s1_base_next;
            s1_d_num_reg   <= s1_d_num_next;
            s1_t_num_reg   <= s1_t_num_next;
        end
    end

    // Stage 2: multiply by the reciprocal of 100.
    logic   s2_full_on_reg;
    addr7_t s2_addr_reg;
    byte_t  s2_base_reg;
    logic [PROD_W-1:0] s2_d_prod_reg, s2_t_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_full_on_reg <= s1_full_on_reg;
            s2_addr_reg    <= s1_addr_reg;
            s2_base_reg    <= s1_base_reg;
            s2_d_prod_reg  <= PROD_W'(s1_d_num_reg) * PROD_W'(RECIP_MUL);
            s2_t_prod_reg  <= PROD_W'(s1_t_num_reg) * PROD_W'(RECIP_MUL);
        end
    end

    // Stage 3: on and off counts, packed into the four data bytes.
    logic [STEP_W-1:0] d_steps, t_steps;
    logic [STEP_W:0]   step_sum;
    count_t on_cnt, off_raw, off_cnt;
    byte_t  s3_data_next [4];

    always_comb
    begin
        d_steps  = s2_d_prod_reg[RECIP_SHIFT +: STEP_W];
        t_steps  = s2_t_prod_reg[RECIP_SHIFT +: STEP_W];
        step_sum = {1'b0, d_steps} + {1'b0, t_steps};
        on_cnt   = (d_steps > STEP_W'(1)) ? (COUNT_W'(d_steps) - 16'd1) : '0;
        off_raw  = COUNT_W'(step_sum) - 16'd1;
        off_cnt  = off_raw;
        if ((step_sum != '0) && (off_raw > STEPS_C))
        begin
            off_cnt = off_raw - STEPS_C;
        end
        s3_data_next[0] = on_cnt[7:0];
        s3_data_next[1] = (on_cnt[15:8] & NIBBLE_MASK)
                          | (s2_full_on_reg ? FULL_ON_BIT : 8'h00);
        s3_data_next[2] = off_cnt[7:0];
        s3_data_next[3] = off_cnt[15:8] & NIBBLE_MASK;
    end

    addr7_t s3_addr_reg;
    byte_t  s3_base_reg;
    byte_t  s3_data_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_addr_reg <= s2_addr_reg;
            s3_base_reg <= s2_base_reg;
            for (int k = 0; k < 4; k++)
            begin
                s3_data_reg[k] <= s3_data_next[k];
            end
        end
    end

    // Stage 4: output register that sends the four writes in order.
    addr7_t s4_addr_reg;
    byte_t  s4_base_reg;
    byte_t  s4_data_reg [4];
    logic [1:0] s4_cnt_next;
    logic   s4_valid_next;

    always_comb
    begin
        s4_valid_next = s4_valid_reg;
        s4_cnt_next   = s4_cnt_reg;
        if (s4_free)
        begin
            s4_valid_next = s3_valid_reg;
            s4_cnt_next   = 2'd0;
        end
        else if (wr_done)
        begin
            s4_cnt_next = s4_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s4_cnt_reg   <= 2'd0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s4_cnt_reg   <= s4_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_free)
        begin
            s4_addr_reg <= s3_addr_reg;
            s4_base_reg <= s3_base_reg;
            for (int k = 0; k < 4; k++)
            begin
                s4_data_reg[k] <= s3_data_reg[k];
            end
        end
    end

    assign wr.valid            = s4_valid_reg;
    assign wr.slave_address    = s4_addr_reg;
    assign wr.register_address = s4_base_reg + BYTE_W'(s4_cnt_reg);
    assign wr.register_data    = s4_data_reg[s4_cnt_reg];
    assign wr.last             = (s4_cnt_reg == 2'd3);

`ifndef SYNTHESIS
    // The write counter only moves while a request is held in the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_cnt_reg != 2'd0) |-> s4_valid_reg)
        else $error("write counter set with empty output stage");

    // A write that is taken before the fourth is followed by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_done && (s4_cnt_reg != 2'd3))
        |=> (s4_valid_reg && (s4_cnt_reg == $past(s4_cnt_reg) + 2'd1)))
        else $error("register write lost or repeated");

    // A stalled count stage keeps its first and last data bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_ready)
        |=> (s3_valid_reg && $stable(s3_data_reg[0]) && $stable(s3_data_reg[3])))
        else $error("count stage changed while stalled");

    // The OFF_H write never carries bits above the count nibble.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && (s4_cnt_reg == 2'd3)) |-> (wr.register_data[7:4] == 4'h0))
        else $error("high bits set in OFF_H write");

    // A request with a device or channel outside the range never enters the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && s1_ready && !in_range) |=> !s1_valid_reg)
        else $error("out of range request entered the pipeline");
`endif

endmodule : pwm_percent_to_register_writes_unit
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM percent to register writes unit testbench
// Sends duty requests over the request channel and checks every register
// write on the output channel against typed bytes or a behavioral model of
// the on and off count arithmetic. Both channels idle at random, the output
// side holds off once for a long stretch, and the delay and bus address
// registers are changed between phases, including their extreme values.
// ----------------------------------------------------------------------------
module tb_top;
    import pwmrw_pkg::*;

    localparam int PWM_STEPS      = 4096;
    localparam int DEVICE_COUNT   = 7;
    localparam int WRITES_PER_REQ = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 23;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int NUM_ROWS       = 25;
    localparam int CFG_DATA_MAX   = (1 << CFG_DAT_W) - 1;
    localparam int CFG_ADDR_DEV1  = CFG_BUS_ADDR_FIRST;
    localparam int CFG_ADDR_DEV7  = CFG_BUS_ADDR_FIRST + DEVICE_COUNT - 1;

    typedef enum int {ROW_CFG, ROW_TYPED, ROW_PREDICT, ROW_DROPPED} row_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_RARE_STALL} rx_mode_t;

    // For configuration rows, dev holds the register index and pct the value.
    typedef struct {
        row_kind_t   kind;
        int          dev;
        int          ch;
        int          pct;
        int          slave;
        int          base;
        logic [31:0] bytes;
    } stim_row_t;

    typedef struct packed {
        addr7_t slave_address;
        byte_t  register_address;
        byte_t  register_data;
        logic   last;
    } reg_write_t;

    // The expected bytes are ON_L, ON_H, OFF_L and OFF_H from the top down.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_TYPED,   1,  1,   0, 64,  6, 32'h99019901},
        '{ROW_TYPED,   7, 16, 100, 96, 66, 32'h99119901},
        '{ROW_TYPED,   4,  8,  50, 68, 34, 32'h99019909},
        '{ROW_TYPED,   2,  3, 127, 65, 14, 32'h99119901},
        '{ROW_DROPPED, 0,  1,  50,  0,  0, 32'h0},
        '{ROW_DROPPED, 3,  0,  50,  0,  0, 32'h0},
        '{ROW_DROPPED, 3, 17,  50,  0,  0, 32'h0},
        '{ROW_DROPPED, 5, 31, 100,  0,  0, 32'h0},
        '{ROW_PREDICT, 6,  9,   1,  0,  0, 32'h0},
        '{ROW_PREDICT, 5,  2,  99,  0,  0, 32'h0},
        '{ROW_PREDICT, 3,  5, 101,  0,  0, 32'h0},
        '{ROW_PREDICT, 1, 16,  33,  0,  0, 32'h0},
        '{ROW_CFG,     CFG_DELAY, 0, 0, 0, 0, 32'h0},
        '{ROW_TYPED,   1,  1,   0, 64,  6, 32'h0000ff0f},
        '{ROW_TYPED,   2,  2, 100, 65, 10, 32'h0010ff0f},
        '{ROW_PREDICT, 3,  4,   1,  0,  0, 32'h0},
        '{ROW_CFG,     CFG_DELAY, 0, PCT_MAX, 0, 0, 32'h0},
        '{ROW_TYPED,   4, 16,   0, 68, 66, 32'hff0fff0f},
        '{ROW_TYPED,   5,  1, 100, 72,  6, 32'hff1fff0f},
        '{ROW_CFG,     CFG_DELAY, 0, CFG_DATA_MAX, 0, 0, 32'h0},
        '{ROW_TYPED,   6,  7,   0, 80, 30, 32'hff0fff0f},
        '{ROW_CFG,     CFG_ADDR_DEV7, 0, CFG_DATA_MAX, 0, 0, 32'h0},
        '{ROW_PREDICT, 7,  2,  64,  0,  0, 32'h0},
        '{ROW_CFG,     CFG_ADDR_DEV1, 0, 0, 0, 0, 32'h0},
        '{ROW_PREDICT, 1,  3, 100,  0,  0, 32'h0}
    };

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    cfg_dat_t cfg_data;

    pwmrw_req_if req_ch ();
    pwmrw_wr_if  wr_ch ();

    pct_t       delay_setting;
    addr7_t     device_addr [1:DEVICE_COUNT];
    reg_write_t pending_writes [$];

    int   error_count    = 0;
    int   writes_checked = 0;
    int   requests_sent  = 0;
    int   dropped_sent   = 0;
    int   cfg_writes     = 0;
    int   burst_left     = 0;
    int   cycle_count    = 0;
    logic hold_request   = 1'b0;

    pwm_percent_to_register_writes_unit
    #(
        .PWM_STEPS    (PWM_STEPS),
        .DEVICE_COUNT (DEVICE_COUNT)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .wr        (wr_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int percent_to_steps(int pct);
        int p;
        p = (pct > PCT_MAX) ? PCT_MAX : pct;
        return (p * PWM_STEPS + ROUND_HALF) / int'(PCT_MAX);
    endfunction

    function automatic void push_channel_writes(int dev, int ch, int pct);
        int         d;
        int         t;
        int         on_count;
        int         off_count;
        byte_t      data [WRITES_PER_REQ];
        byte_t      base;
        reg_write_t w;
        if (dev < 1 || dev > DEVICE_COUNT || ch < 1 || ch > CHANNEL_COUNT)
            return;
        d = percent_to_steps(delay_setting);
        t = percent_to_steps(pct);
        on_count = (d > 1) ? d - 1 : 0;
        off_count = (d + t - 1) & 16'hffff;
        if (d + t != 0 && off_count > PWM_STEPS)
            off_count -= PWM_STEPS;
        data[0] = byte_t'(on_count);
        data[1] = byte_t'(on_count >> 8) & NIBBLE_MASK;
        if (pct >= PCT_MAX)
            data[1] |= FULL_ON_BIT;
        data[2] = byte_t'(off_count);
        data[3] = byte_t'(off_count >> 8) & NIBBLE_MASK;
        base = byte_t'(4 * (ch - 1)) + FIRST_LED_REG;
        for (int k = 0; k < WRITES_PER_REQ; k++)
        begin
            w.slave_address    = device_addr[dev];
            w.register_address = base + byte_t'(k);
            w.register_data    = data[k];
            w.last             = (k == WRITES_PER_REQ - 1);
            pending_writes.push_back(w);
        end
    endfunction

    function automatic void push_typed_writes(stim_row_t row);
        reg_write_t w;
        for (int k = 0; k < WRITES_PER_REQ; k++)
        begin
            w.slave_address    = addr7_t'(row.slave);
            w.register_address = byte_t'(row.base + k);
            w.register_data    = row.bytes[31 - 8 * k -: 8];
            w.last             = (k == WRITES_PER_REQ - 1);
            pending_writes.push_back(w);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] expected,
                                        logic [7:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected, actual);
            error_count++;
        end
    endfunction

    task automatic write_register(cfg_idx_t idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = cfg_dat_t'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_DELAY)
            delay_setting = pct_t'(value);
        else
            device_addr[int'(idx) - int'(CFG_BUS_ADDR_FIRST) + 1] = addr7_t'(value);
        cfg_writes++;
    endtask

    task automatic settle_block(int tail);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (tail) @(negedge clk);
    endtask

    task automatic offer_request(int dev, int ch, int pct);
        int gap;
        if (burst_left == 0)
        begin
            @(negedge clk);
            req_ch.valid         = 1'b0;
            req_ch.device_number = dev_t'($urandom);
            req_ch.channel       = chan_t'($urandom);
            req_ch.pwm_percent   = pct_t'($urandom);
            gap = $urandom_range(0, 5);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
        end
        @(negedge clk);
        req_ch.valid         = 1'b1;
        req_ch.device_number = dev_t'(dev);
        req_ch.channel       = chan_t'(ch);
        req_ch.pwm_percent   = pct_t'(pct);
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        requests_sent++;
        if (dev < 1 || dev > DEVICE_COUNT || ch < 1 || ch > CHANNEL_COUNT)
            dropped_sent++;
    endtask

    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        wr_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                wr_ch.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:       wr_ch.ready = 1'b1;
                    RX_COIN:       wr_ch.ready = $urandom_range(0, 1);
                    RX_THIRD:      wr_ch.ready = (tick % 3 == 0);
                    RX_RARE_STALL: wr_ch.ready = ($urandom_range(0, 9) != 0);
                    default:       wr_ch.ready = 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : write_monitor
        reg_write_t exp_w;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %0h %0h %0h %0b",
                         $time, wr_ch.slave_address, wr_ch.register_address,
                         wr_ch.register_data, wr_ch.last);
                error_count++;
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                check_field("slave_address", exp_w.slave_address, wr_ch.slave_address);
                check_field("register_address", exp_w.register_address,
                            wr_ch.register_address);
                check_field("register_data", exp_w.register_data, wr_ch.register_data);
                check_field("last", exp_w.last, wr_ch.last);
                writes_checked++;
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int roll;
        int dev;
        int ch;
        int pct;
        int d;
        int valid_items;
        int items_in_phase;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_DELAY;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.device_number = '0;
        req_ch.channel       = '0;
        req_ch.pwm_percent   = '0;
        delay_setting        = DELAY_RST;
        for (d = 1; d <= DEVICE_COUNT; d++)
            device_addr[d] = BUS_ADDR_RST[d - 1];
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_block(DRAIN_CYCLES);
                write_register(cfg_idx_t'(directed_rows[i].dev), directed_rows[i].pct);
            end
            else
            begin
                offer_request(directed_rows[i].dev, directed_rows[i].ch,
                              directed_rows[i].pct);
                if (directed_rows[i].kind == ROW_TYPED)
                    push_typed_writes(directed_rows[i]);
                else
                    push_channel_writes(directed_rows[i].dev, directed_rows[i].ch,
                                        directed_rows[i].pct);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_block(DRAIN_CYCLES);
            if (phase == 0)
            begin
                write_register(CFG_DELAY, $urandom_range(0, PCT_MAX));
                for (d = 1; d <= DEVICE_COUNT; d++)
                    write_register(cfg_idx_t'(CFG_BUS_ADDR_FIRST + d - 1),
                                   $urandom_range(0, CFG_DATA_MAX));
            end
            else
            begin
                roll = $urandom_range(0, 9);
                write_register(CFG_DELAY, (roll < 2) ? 0 :
                                          (roll < 4) ? PCT_MAX :
                                          (roll < 5) ? CFG_DATA_MAX :
                                          $urandom_range(0, PCT_MAX));
                repeat ($urandom_range(1, 3))
                begin
                    d    = $urandom_range(1, DEVICE_COUNT);
                    roll = $urandom_range(0, 7);
                    write_register(cfg_idx_t'(CFG_BUS_ADDR_FIRST + d - 1),
                                   (roll == 0) ? 0 :
                                   (roll == 1) ? CFG_DATA_MAX :
                                   $urandom_range(0, CFG_DATA_MAX));
                end
            end
            if (phase == 2)
                hold_request = 1'b1;
            valid_items    = 0;
            items_in_phase = 0;
            while (valid_items < PHASE_ITEMS)
            begin
                if (phase == 4 && items_in_phase == PHASE_ITEMS / 2)
                    settle_block(0);
                roll = $urandom_range(0, 99);
                dev  = $urandom_range(1, DEVICE_COUNT);
                ch   = $urandom_range(1, CHANNEL_COUNT);
                if (roll < 75)
                    pct = $urandom_range(0, PCT_MAX);
                else if (roll < 85)
                    pct = $urandom_range(0, 1) ? PCT_MAX : 0;
                else
                    pct = $urandom_range(PCT_MAX + 1, CFG_DATA_MAX);
                if (roll >= 92)
                begin
                    case ($urandom_range(0, 2))
                        0:       dev = 0;
                        1:       ch = 0;
                        default: ch = $urandom_range(CHANNEL_COUNT + 1, 31);
                    endcase
                end
                else
                    valid_items++;
                items_in_phase++;
                offer_request(dev, ch, pct);
                push_channel_writes(dev, ch, pct);
            end
        end

        settle_block(DRAIN_CYCLES);
        $display("Run covered %0d requests, %0d of them out of range, and %0d checked writes,",
                 requests_sent, dropped_sent, writes_checked);
        $display("with %0d register updates, one long output stall and random idling.",
                 cfg_writes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_top
